/* rtl/rtad_pkg.sv */
package rtad_pkg;

	// field widths fixed by the item format
	localparam int ACTION_W = 3;
	localparam int CHAR_W   = 8;
	localparam int COUNT_W  = 4;

	// shift-and-add-3 iterations per pipeline stage
	localparam int DABBLE_STEPS = 8;

	// conversion modes
	localparam logic [ACTION_W-1:0] ACT_DEC   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_OCT   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_HEX   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_HEXUP = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_ADDR  = 3'd4;

	// ascii codes
	localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_X      = 8'h78;
	localparam logic [CHAR_W-1:0] ASCII_LOW_A  = 8'h61;
	localparam logic [CHAR_W-1:0] ASCII_UP_A   = 8'h41;

	// one digit to its ascii character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] base;
		if (d < 4'd10) begin
			base = ASCII_ZERO;
		end else if (upper) begin
			base = ASCII_UP_A - 8'd10;
		end else begin
			base = ASCII_LOW_A - 8'd10;
		end
		return base + {4'b0000, d};
	endfunction

endpackage

/* rtl/rtad_in_if.sv */
interface rtad_in_if #(
	parameter int VALUE_BITS = 32
);
	import rtad_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [VALUE_BITS-1:0]  value;
	logic [ACTION_W-1:0]    action;

	modport source (output valid, output value, output action, input ready);
	modport sink   (input valid, input value, input action, output ready);

endinterface

/* rtl/rtad_out_if.sv */
interface rtad_out_if;
	import rtad_pkg::*;

	logic                valid;
	logic                ready;
	logic [CHAR_W-1:0]   character;
	logic                last;
	logic [COUNT_W-1:0]  char_count;

	modport source (output valid, output character, output last, output char_count,
		input ready);
	modport sink   (input valid, input character, input last, input char_count,
		output ready);

endinterface

/* rtl/rtad_dabble_stage.sv */
module rtad_dabble_stage #(
	parameter int VB    = 32,
	parameter int DW    = 40,
	parameter int STEPS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [DW-1:0]                    in_bcd,
	input  logic [VB-1:0]                    in_shift,
	input  logic [VB-1:0]                    in_raw,
	input  logic [rtad_pkg::ACTION_W-1:0]    in_action,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [DW-1:0]                    out_bcd,
	output logic [VB-1:0]                    out_shift,
	output logic [VB-1:0]                    out_raw,
	output logic [rtad_pkg::ACTION_W-1:0]    out_action
);
	import rtad_pkg::*;

	localparam int ND = DW / 4;

	logic                 valid_s1;
	logic [DW-1:0]        bcd_s1;
	logic [VB-1:0]        shift_s1;
	logic [VB-1:0]        raw_s1;
	logic [ACTION_W-1:0]  action_s1;
	logic [DW-1:0]        bcd_c;
	logic [VB-1:0]        shift_c;

	// double dabble: adjust digits then shift in the next value bit
	always_comb begin
		bcd_c   = in_bcd;
		shift_c = in_shift;
		for (int s = 0; s < STEPS; s++) begin
			for (int j = 0; j < ND; j++) begin
				if (bcd_c[4*j +: 4] >= 4'd5) begin
					bcd_c[4*j +: 4] = bcd_c[4*j +: 4] + 4'd3;
				end
			end
			{bcd_c, shift_c} = {bcd_c[DW-2:0], shift_c, 1'b0};
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bcd_s1    <= bcd_c;
			shift_s1  <= shift_c;
			raw_s1    <= in_raw;
			action_s1 <= in_action;
		end
	end

	assign out_valid  = valid_s1;
	assign out_bcd    = bcd_s1;
	assign out_shift  = shift_s1;
	assign out_raw    = raw_s1;
	assign out_action = action_s1;

endmodule

/* rtl/rtad_format.sv */
module rtad_format #(
	parameter int VB = 32,
	parameter int DW = 40,
	parameter int ND = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [DW-1:0]                    in_bcd,
	input  logic [VB-1:0]                    in_raw,
	input  logic [rtad_pkg::ACTION_W-1:0]    in_action,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [4*ND-1:0]                  out_digits,
	output logic [$clog2(ND)-1:0]            out_msd,
	output logic                             out_upper,
	output logic                             out_prefix,
	output logic [rtad_pkg::COUNT_W-1:0]     out_count
);
	import rtad_pkg::*;

	localparam int IW   = $clog2(ND);
	localparam int DEC  = DW / 4;
	localparam int OCTW = 3 * ND;
	localparam int HEXW = 4 * ND;

	logic                 valid_s1;
	logic [4*ND-1:0]      digits_s1;
	logic [IW-1:0]        msd_s1;
	logic                 upper_s1;
	logic                 prefix_s1;
	logic [COUNT_W-1:0]   count_s1;

	logic [4*ND-1:0]      digits_c;
	logic [IW-1:0]        msd_c;
	logic                 upper_c;
	logic                 prefix_c;
	logic                 is_oct_c;
	logic                 is_hex_c;
	logic [COUNT_W-1:0]   count_c;
	logic [OCTW-1:0]      raw_oct;
	logic [HEXW-1:0]      raw_hex;

	assign raw_oct = OCTW'(in_raw);
	assign raw_hex = HEXW'(in_raw);

	// mode decode, unused codes fall back to decimal
	always_comb begin
		is_oct_c = 1'b0;
		is_hex_c = 1'b0;
		upper_c  = 1'b0;
		prefix_c = 1'b0;
		case (in_action)
			ACT_OCT: is_oct_c = 1'b1;
			ACT_HEX: is_hex_c = 1'b1;
			ACT_HEXUP: begin
				is_hex_c = 1'b1;
				upper_c  = 1'b1;
			end
			ACT_ADDR: begin
				is_hex_c = 1'b1;
				prefix_c = 1'b1;
			end
			default: is_oct_c = 1'b0;
		endcase
	end

	// digit select per radix and most significant nonzero digit search
	always_comb begin
		digits_c = '0;
		msd_c    = '0;
		for (int j = 0; j < ND; j++) begin
			if (is_oct_c) begin
				digits_c[4*j +: 4] = {1'b0, raw_oct[3*j +: 3]};
			end else if (is_hex_c) begin
				digits_c[4*j +: 4] = raw_hex[4*j +: 4];
			end else if (j < DEC) begin
				digits_c[4*j +: 4] = in_bcd[4*j +: 4];
			end
		end
		for (int j = 1; j < ND; j++) begin
			if (digits_c[4*j +: 4] != 4'd0) begin
				msd_c = IW'(j);
			end
		end
	end

	// character total, kept to the field width
	assign count_c = COUNT_W'(msd_c) + 4'd1 + (prefix_c ? 4'd2 : 4'd0);

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			digits_s1 <= digits_c;
			msd_s1    <= msd_c;
			upper_s1  <= upper_c;
			prefix_s1 <= prefix_c;
			count_s1  <= count_c;
		end
	end

	assign out_valid  = valid_s1;
	assign out_digits = digits_s1;
	assign out_msd    = msd_s1;
	assign out_upper  = upper_s1;
	assign out_prefix = prefix_s1;
	assign out_count  = count_s1;

endmodule

/* rtl/rtad_serializer.sv */
module rtad_serializer #(
	parameter int ND = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [4*ND-1:0]                  in_digits,
	input  logic [$clog2(ND)-1:0]            in_msd,
	input  logic                             in_upper,
	input  logic                             in_prefix,
	input  logic [rtad_pkg::COUNT_W-1:0]     in_count,
	rtad_out_if.source                       result
);
	import rtad_pkg::*;

	localparam int IW = $clog2(ND);

	logic                busy_q;
	logic [1:0]          pfx_q;
	logic [IW-1:0]       idx_q;
	logic [3:0]          digits_q [ND];
	logic                upper_q;
	logic [COUNT_W-1:0]  count_q;
	logic                last_c;
	logic                take_c;

	// current character: prefix first, then digits from the top
	assign last_c = (pfx_q == 2'd0) && (idx_q == '0);
	assign take_c = busy_q && result.ready;

	always_comb begin
		if (pfx_q == 2'd2) begin
			result.character = ASCII_ZERO;
		end else if (pfx_q == 2'd1) begin
			result.character = ASCII_X;
		end else begin
			result.character = digit_char(digits_q[idx_q], upper_q);
		end
	end

	assign result.valid      = busy_q;
	assign result.last       = last_c;
	assign result.char_count = last_c ? count_q : '0;

	// next number loads as the final character of the current one leaves
	assign in_ready = !busy_q || (result.ready && last_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pfx_q  <= 2'd0;
			idx_q  <= '0;
		end else if (in_ready) begin
			busy_q <= in_valid;
			if (in_valid) begin
				pfx_q <= in_prefix ? 2'd2 : 2'd0;
				idx_q <= in_msd;
			end
		end else if (take_c) begin
			if (pfx_q != 2'd0) begin
				pfx_q <= pfx_q - 2'd1;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int j = 0; j < ND; j++) begin
				digits_q[j] <= in_digits[4*j +: 4];
			end
			upper_q <= in_upper;
			count_q <= in_count;
		end
	end

	// a number in flight stays until its final character is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		take_c && !last_c |=> busy_q)
		else $error("serializer dropped a number before its last character");

	// prefix characters step down one per transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		take_c && pfx_q != 2'd0 |=> pfx_q == $past(pfx_q) - 2'd1)
		else $error("prefix counter did not step");

	// digit index steps down one per transaction after the prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		take_c && pfx_q == 2'd0 && idx_q != '0 |=> idx_q == $past(idx_q) - 1'b1)
		else $error("digit index did not step");

	// an idle serializer always takes the next number
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> in_ready)
		else $error("idle serializer refused a number");

endmodule

/* rtl/radix_to_ascii_digits_unit.sv */
// pipeline: ceil(VALUE_BITS/8) binary-to-bcd stages, one format stage and the
// character register in front of the result channel
// throughput: one character per cycle while result.ready holds; a number has 1 to 11
// characters at 32 bits, sent one at a time over the single-character result channel
// reset: arst_n clears every stage valid and the serializer busy, prefix and index registers at once
module radix_to_ascii_digits_unit #(
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	rtad_in_if.sink    operand,
	rtad_out_if.source result
);
	import rtad_pkg::*;

	localparam int DEC  = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DW   = 4 * DEC;
	localparam int ND   = (VALUE_BITS + 2) / 3;
	localparam int IW   = $clog2(ND);
	localparam int NSTG = (VALUE_BITS + DABBLE_STEPS - 1) / DABBLE_STEPS;

	logic                 stg_valid  [NSTG+1];
	logic                 stg_ready  [NSTG+1];
	logic [DW-1:0]        stg_bcd    [NSTG+1];
	logic [VALUE_BITS-1:0] stg_shift [NSTG+1];
	logic [VALUE_BITS-1:0] stg_raw   [NSTG+1];
	logic [ACTION_W-1:0]  stg_action [NSTG+1];

	logic                 fmt_valid;
	logic                 fmt_ready;
	logic [4*ND-1:0]      fmt_digits;
	logic [IW-1:0]        fmt_msd;
	logic                 fmt_upper;
	logic                 fmt_prefix;
	logic [COUNT_W-1:0]   fmt_count;

	// input side of the conversion chain
	assign stg_valid[0]  = operand.valid;
	assign operand.ready = stg_ready[0];
	assign stg_bcd[0]    = '0;
	assign stg_shift[0]  = operand.value;
	assign stg_raw[0]    = operand.value;
	assign stg_action[0] = operand.action;

	// binary to bcd, a group of value bits per stage
	for (genvar g = 0; g < NSTG; g++) begin : g_dabble
		localparam int STEPS = (g == NSTG - 1) ?
			(VALUE_BITS - DABBLE_STEPS * (NSTG - 1)) : DABBLE_STEPS;

		rtad_dabble_stage #(
			.VB    (VALUE_BITS),
			.DW    (DW),
			.STEPS (STEPS)
		) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (stg_valid[g]),
			.in_ready   (stg_ready[g]),
			.in_bcd     (stg_bcd[g]),
			.in_shift   (stg_shift[g]),
			.in_raw     (stg_raw[g]),
			.in_action  (stg_action[g]),
			.out_valid  (stg_valid[g+1]),
			.out_ready  (stg_ready[g+1]),
			.out_bcd    (stg_bcd[g+1]),
			.out_shift  (stg_shift[g+1]),
			.out_raw    (stg_raw[g+1]),
			.out_action (stg_action[g+1])
		);
	end

	// digit selection and length
	rtad_format #(
		.VB (VALUE_BITS),
		.DW (DW),
		.ND (ND)
	) u_format (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (stg_valid[NSTG]),
		.in_ready   (stg_ready[NSTG]),
		.in_bcd     (stg_bcd[NSTG]),
		.in_raw     (stg_raw[NSTG]),
		.in_action  (stg_action[NSTG]),
		.out_valid  (fmt_valid),
		.out_ready  (fmt_ready),
		.out_digits (fmt_digits),
		.out_msd    (fmt_msd),
		.out_upper  (fmt_upper),
		.out_prefix (fmt_prefix),
		.out_count  (fmt_count)
	);

	// one character per transaction
	rtad_serializer #(
		.ND (ND)
	) u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fmt_valid),
		.in_ready  (fmt_ready),
		.in_digits (fmt_digits),
		.in_msd    (fmt_msd),
		.in_upper  (fmt_upper),
		.in_prefix (fmt_prefix),
		.in_count  (fmt_count),
		.result    (result)
	);

endmodule
